[src/pointwise_conv_bias_relu_macros.svh]
// Assertion macros for the pointwise convolution block.
// Expects clk and rst in the scope of each use.
`ifndef POINTWISE_CONV_BIAS_RELU_MACROS_SVH
`define POINTWISE_CONV_BIAS_RELU_MACROS_SVH

// Same-cycle implication.
`define PCBR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcbr: assertion failed");

// Next-cycle implication.
`define PCBR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcbr: assertion failed");

`endif

[src/pcbr_pkg.sv]
// Package for the pointwise convolution block: payload types, command struct,
// action and register index codes. No dependencies.
`default_nettype none

package pcbr_pkg;

  localparam int ACTION_W     = 2;
  localparam int FILTER_SEL_W = 4;
  localparam int CHAN_SEL_W   = 6;
  localparam int VALUE_W      = 16;
  localparam int ACC_W        = 40;
  localparam int PROD_W       = 32;
  localparam int FRAC_SHIFT   = 12;

  localparam int NUM_FILTERS_W  = 5;
  localparam int NUM_CHANNELS_W = 7;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 7;

  localparam logic [ACTION_W-1:0] ACT_LOAD_WEIGHT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_BIAS   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SAMPLE      = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_FILTERS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_CHANNELS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BIAS_ENABLE  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_RELU_ENABLE  = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic [FILTER_SEL_W-1:0]   filter_select;
    logic [CHAN_SEL_W-1:0]     channel_select;
    logic signed [VALUE_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [FILTER_SEL_W-1:0]   out_filter;
    logic signed [VALUE_W-1:0] out_value;
    logic                      last_of_pixel;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;    // input transfer this cycle
    logic mac;       // issue one multiply-accumulate for the current filter
    logic load_out;  // compute the result of the current filter into the output register
    logic last;      // current filter is the last one in use
    logic clear;     // pixel done: clear all accumulators
  } cmd_t;

endpackage

`default_nettype wire

[src/pcbr_stream_if.sv]
// Valid/ready stream interface with a typed payload.
// Used for both the input item and the result channel.
`default_nettype none

interface pcbr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/pcbr_ctrl.sv]
// Sequencer for the pointwise convolution: filter and channel counters,
// MAC issue, pipeline drain, and result emission. Uses pcbr_pkg.
`default_nettype none

module pcbr_ctrl #(
  parameter int MAX_FILTERS  = 16,
  parameter int MAX_CHANNELS = 64,
  parameter int FW  = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1,
  parameter int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  parameter int FCW = $clog2(MAX_FILTERS + 1),
  parameter int CCW = $clog2(MAX_CHANNELS + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [pcbr_pkg::ACTION_W-1:0] in_action,
  output logic                               in_ready,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  input  wire logic [FCW-1:0]                nf,
  input  wire logic [CCW-1:0]                nc,
  output pcbr_pkg::cmd_t                     cmd,
  output logic [FW-1:0]                      filter,
  output logic [CW-1:0]                      channel
);
  import pcbr_pkg::*;

  typedef enum logic [2:0] {
    IDLE, MAC, DRAIN1, DRAIN2, OUT_READ, OUT_CALC, OUT_HOLD
  } state_t;

  state_t        state;
  logic [FW-1:0] filt;
  logic [CW-1:0] chan;
  logic [CW-1:0] chan_clamped;
  logic          last_filter;
  logic          more_channels;
  logic          sample_take;

  assign last_filter   = (FCW'(filt) + FCW'(1)) == nf;
  // a shrunk channel count pulls the position back onto the last channel
  assign chan_clamped  = (CCW'(chan) >= nc) ? CW'(nc - CCW'(1)) : chan;
  assign more_channels = (CCW'(chan) + CCW'(1)) < nc;

  assign in_ready    = (state == IDLE);
  assign out_valid   = (state == OUT_HOLD);
  assign sample_take = in_valid && (state == IDLE) && (in_action == ACT_SAMPLE);

  assign filter  = filt;
  assign channel = chan;

  always_comb begin
    cmd          = '0;
    cmd.accept   = in_valid && in_ready;
    cmd.mac      = (state == MAC);
    cmd.load_out = (state == OUT_CALC);
    cmd.last     = last_filter;
    cmd.clear    = (state == OUT_HOLD) && out_ready && last_filter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      filt  <= '0;
      chan  <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (sample_take) begin
            chan  <= chan_clamped;
            filt  <= '0;
            state <= MAC;
          end
        end
        MAC: begin
          if (last_filter) state <= DRAIN1;
          else filt <= filt + FW'(1);
        end
        // DRAIN1 and DRAIN2 let the last accumulator write land
        DRAIN1: state <= DRAIN2;
        DRAIN2: begin
          filt <= '0;
          if (more_channels) begin
            chan  <= chan + CW'(1);
            state <= IDLE;
          end else begin
            state <= OUT_READ;
          end
        end
        OUT_READ: state <= OUT_CALC;
        OUT_CALC: state <= OUT_HOLD;
        OUT_HOLD: begin
          if (out_ready) begin
            if (last_filter) begin
              chan  <= '0;
              state <= IDLE;
            end else begin
              filt  <= filt + FW'(1);
              state <= OUT_READ;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/pcbr_dp.sv]
// Datapath: config registers, weight/bias/accumulator memories, shared MAC
// pipeline, and the bias/shift/saturate/ReLU output stage. Uses pcbr_pkg.
`default_nettype none

module pcbr_dp #(
  parameter int MAX_FILTERS  = 16,
  parameter int MAX_CHANNELS = 64,
  parameter int FW  = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1,
  parameter int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  parameter int FCW = $clog2(MAX_FILTERS + 1),
  parameter int CCW = $clog2(MAX_CHANNELS + 1)
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [pcbr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pcbr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire pcbr_pkg::in_item_t              in_data,
  input  wire pcbr_pkg::cmd_t                  cmd,
  input  wire logic [FW-1:0]                   filter,
  input  wire logic [CW-1:0]                   channel,
  output logic [FCW-1:0]                       nf,
  output logic [CCW-1:0]                       nc,
  output pcbr_pkg::out_item_t                  out_data
);
  import pcbr_pkg::*;

  localparam int WDEPTH = MAX_FILTERS * (2 ** CW);

  logic [NUM_FILTERS_W-1:0]  num_filters;
  logic [NUM_CHANNELS_W-1:0] num_channels;
  logic                      bias_enable;
  logic                      relu_enable;

  logic signed [VALUE_W-1:0] weight_mem [WDEPTH];
  logic signed [VALUE_W-1:0] bias_mem [MAX_FILTERS];
  logic [ACC_W-1:0]          acc_mem [MAX_FILTERS];
  logic [MAX_FILTERS-1:0]    acc_vld;

  logic signed [VALUE_W-1:0] sample;
  logic signed [VALUE_W-1:0] weight_rd;
  logic signed [VALUE_W-1:0] bias_rd;
  logic [ACC_W-1:0]          acc_rd;
  logic                      vld_rd;

  logic                      mac_s1;
  logic [FW-1:0]             f_s1;
  logic                      mac_s2;
  logic [FW-1:0]             f_s2;
  logic signed [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]          acc_base;
  logic [ACC_W-1:0]          acc_sum;

  logic                      wr_weight;
  logic                      wr_bias;
  logic [ACC_W-1:0]          acc_cur;
  logic [ACC_W-1:0]          biased;
  logic [VALUE_W-1:0]        sat;
  logic [VALUE_W-1:0]        result;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_filters  <= NUM_FILTERS_W'(1);
      num_channels <= NUM_CHANNELS_W'(1);
      bias_enable  <= 1'b0;
      relu_enable  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_FILTERS:  num_filters  <= cfg_data[NUM_FILTERS_W-1:0];
        CFG_NUM_CHANNELS: num_channels <= cfg_data[NUM_CHANNELS_W-1:0];
        CFG_BIAS_ENABLE:  bias_enable  <= cfg_data[0];
        CFG_RELU_ENABLE:  relu_enable  <= cfg_data[0];
      endcase
    end
  end

  always_comb begin
    if (num_filters == '0) nf = FCW'(1);
    else if (int'(num_filters) > MAX_FILTERS) nf = FCW'(MAX_FILTERS);
    else nf = FCW'(num_filters);
  end

  always_comb begin
    if (num_channels == '0) nc = CCW'(1);
    else if (int'(num_channels) > MAX_CHANNELS) nc = CCW'(MAX_CHANNELS);
    else nc = CCW'(num_channels);
  end

  // loads
  assign wr_weight = cmd.accept && (in_data.action == ACT_LOAD_WEIGHT) &&
                     (int'(in_data.filter_select) < MAX_FILTERS) &&
                     (int'(in_data.channel_select) < MAX_CHANNELS);
  assign wr_bias   = cmd.accept && (in_data.action == ACT_LOAD_BIAS) &&
                     (int'(in_data.filter_select) < MAX_FILTERS);

  always_ff @(posedge clk) begin
    if (wr_weight) begin
      weight_mem[{FW'(in_data.filter_select), CW'(in_data.channel_select)}] <=
        in_data.item_value;
    end
    weight_rd <= weight_mem[{filter, channel}];
  end

  always_ff @(posedge clk) begin
    if (wr_bias) bias_mem[FW'(in_data.filter_select)] <= in_data.item_value;
    bias_rd <= bias_mem[filter];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_data.action == ACT_SAMPLE)) sample <= in_data.item_value;
  end

  // accumulator memory; an entry without its valid bit reads as zero
  always_ff @(posedge clk) begin
    if (mac_s2) acc_mem[f_s2] <= acc_sum;
    acc_rd <= acc_mem[filter];
    vld_rd <= acc_vld[filter];
  end

  always_ff @(posedge clk) begin
    if (rst) acc_vld <= '0;
    else if (cmd.clear) acc_vld <= '0;
    else if (mac_s2) acc_vld[f_s2] <= 1'b1;
  end

  // MAC pipeline: read, multiply, accumulate-write
  always_ff @(posedge clk) begin
    if (rst) begin
      mac_s1 <= 1'b0;
      mac_s2 <= 1'b0;
    end else begin
      mac_s1 <= cmd.mac;
      mac_s2 <= mac_s1;
    end
  end

  always_ff @(posedge clk) begin
    f_s1     <= filter;
    f_s2     <= f_s1;
    prod     <= weight_rd * sample;
    acc_base <= vld_rd ? acc_rd : '0;
  end

  assign acc_sum = acc_base + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

  // output stage: bias, floor shift by 12, saturate, ReLU
  assign acc_cur = vld_rd ? acc_rd : '0;
  assign biased  = bias_enable ?
                   acc_cur + {{(ACC_W - VALUE_W - FRAC_SHIFT){bias_rd[VALUE_W-1]}},
                              bias_rd, {FRAC_SHIFT{1'b0}}} :
                   acc_cur;

  always_comb begin
    // shifted value fits 16 bits when the bits above its sign all match it
    if ((&biased[ACC_W-1:FRAC_SHIFT+VALUE_W-1]) ||
        !(|biased[ACC_W-1:FRAC_SHIFT+VALUE_W-1])) begin
      sat = biased[FRAC_SHIFT+VALUE_W-1:FRAC_SHIFT];
    end else if (biased[ACC_W-1]) begin
      sat = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(VALUE_W-1){1'b1}}};
    end
    result = (relu_enable && sat[VALUE_W-1]) ? '0 : sat;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.out_filter    <= FILTER_SEL_W'(filter);
      out_data.out_value     <= result;
      out_data.last_of_pixel <= cmd.last;
    end
  end

endmodule

`default_nettype wire

[src/pointwise_conv_bias_relu.sv]
// Pointwise 1x1 convolution with bias and ReLU. A sample issues one MAC per
// filter through the shared multiplier, then drains the pipeline in DRAIN1 and
// DRAIN2. After the last channel, each result is read, computed and held until
// the sink takes it; no input is taken until the last result of the pixel is
// taken. Reset clears control, config (1, 1, 0, 0) and accumulators;
// weight and bias memories keep their contents and must be loaded before use.
`default_nettype none

module pointwise_conv_bias_relu #(
  parameter int MAX_FILTERS  = 16,
  parameter int MAX_CHANNELS = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [pcbr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pcbr_pkg::CFG_DATA_W-1:0]  cfg_data,
  pcbr_stream_if.sink                           in_items,
  pcbr_stream_if.source                         out_items
);
  import pcbr_pkg::*;

  localparam int FW  = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int FCW = $clog2(MAX_FILTERS + 1);
  localparam int CCW = $clog2(MAX_CHANNELS + 1);

  cmd_t          cmd;
  logic [FW-1:0] filter;
  logic [CW-1:0] channel;
  logic [FCW-1:0] nf;
  logic [CCW-1:0] nc;
  in_item_t      in_data;
  out_item_t     out_data;
  logic          in_ready;
  logic          out_valid;

  assign in_data         = in_items.data;
  assign in_items.ready  = in_ready;
  assign out_items.valid = out_valid;
  assign out_items.data  = out_data;

  pcbr_ctrl #(
    .MAX_FILTERS (MAX_FILTERS),
    .MAX_CHANNELS(MAX_CHANNELS),
    .FW (FW),
    .CW (CW),
    .FCW(FCW),
    .CCW(CCW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_items.valid),
    .in_action(in_data.action),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_items.ready),
    .nf       (nf),
    .nc       (nc),
    .cmd      (cmd),
    .filter   (filter),
    .channel  (channel)
  );

  pcbr_dp #(
    .MAX_FILTERS (MAX_FILTERS),
    .MAX_CHANNELS(MAX_CHANNELS),
    .FW (FW),
    .CW (CW),
    .FCW(FCW),
    .CCW(CCW)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .filter   (filter),
    .channel  (channel),
    .nf       (nf),
    .nc       (nc),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

[src/pcbr_checker.sv]
// Port-level checks for pointwise_conv_bias_relu, bound to the top level.
// Uses pcbr_pkg and the assertion macros header.
`default_nettype none
`include "pointwise_conv_bias_relu_macros.svh"

module pcbr_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic [pcbr_pkg::ACTION_W-1:0] in_action,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          out_last
);
  import pcbr_pkg::*;

  // a stalled result stays offered
  `PCBR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // no input is taken while results of a pixel are pending
  `PCBR_ASSERT_IMPL(a_no_overlap, out_valid, !in_ready)
  // loads and unknown actions never start a result
  `PCBR_ASSERT_NEXT(a_load_silent, in_valid && in_ready && in_action != ACT_SAMPLE, !out_valid)
  // after the last result of a pixel the block is ready again
  `PCBR_ASSERT_NEXT(a_pixel_done, out_valid && out_ready && out_last, in_ready && !out_valid)

endmodule

bind pointwise_conv_bias_relu pcbr_checker u_pcbr_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_items.valid),
  .in_ready (in_items.ready),
  .in_action(in_items.data.action),
  .out_valid(out_items.valid),
  .out_ready(out_items.ready),
  .out_last (out_items.data.last_of_pixel)
);

`default_nettype wire
